### rtl/core/osas_pkg.sv
// osas_pkg: shared types and constants for the obstacle scan/avoid sequencer
// register indexes, reset values, scan phase codes, config and result words
// no dependencies
package osas_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_CLEAR_DISTANCE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_CRUISE_SPEED   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_DWELL_TICKS    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_REFRESH_TICKS  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_TURN_STEP      = 3'd4;

   localparam logic [9:0]  RST_CLEAR_DISTANCE = 10'd15;
   localparam logic [7:0]  RST_CRUISE_SPEED   = 8'd20;
   localparam logic [15:0] RST_DWELL_TICKS    = 16'd1500;
   localparam logic [15:0] RST_REFRESH_TICKS  = 16'd20;
   localparam logic [8:0]  RST_TURN_STEP      = 9'd90;

   // scan phase codes
   localparam logic [3:0] PH_START       = 4'd0;
   localparam logic [3:0] PH_LEFT_SAMPLE = 4'd1;
   localparam logic [3:0] PH_LEFT_BACK   = 4'd2;
   localparam logic [3:0] PH_CENTER_1    = 4'd3;
   localparam logic [3:0] PH_TURN_RIGHT  = 4'd4;
   localparam logic [3:0] PH_RIGHT_SAMPLE = 4'd5;
   localparam logic [3:0] PH_RIGHT_BACK  = 4'd6;
   localparam logic [3:0] PH_CENTER_2    = 4'd7;
   localparam logic [3:0] PH_CHOOSE      = 4'd8;
   localparam logic [3:0] PH_RESUME      = 4'd9;

   typedef struct packed {
      logic [9:0]  clear_distance;
      logic [7:0]  cruise_speed;
      logic [15:0] dwell_ticks;
      logic [15:0] refresh_ticks;
      logic [8:0]  turn_step;
   } osas_cfg_type;

   typedef struct packed {
      logic [7:0]         drive_speed;
      logic signed [15:0] target_heading;
      logic               avoiding;
      logic [3:0]         scan_phase;
      logic [9:0]         left_clearance;
      logic [9:0]         right_clearance;
   } osas_rsp_type;

endpackage

### rtl/core/osas_csr.sv
// osas_csr: configuration registers written through the plain write port
// depends on osas_pkg
module osas_csr
   import osas_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   output osas_cfg_type             cfg
);

   osas_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clear_distance <= RST_CLEAR_DISTANCE;
         cfg_ff.cruise_speed   <= RST_CRUISE_SPEED;
         cfg_ff.dwell_ticks    <= RST_DWELL_TICKS;
         cfg_ff.refresh_ticks  <= RST_REFRESH_TICKS;
         cfg_ff.turn_step      <= RST_TURN_STEP;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CLEAR_DISTANCE: cfg_ff.clear_distance <= csr_data[9:0];
            CSR_CRUISE_SPEED:   cfg_ff.cruise_speed   <= csr_data[7:0];
            CSR_DWELL_TICKS:    cfg_ff.dwell_ticks    <= csr_data;
            CSR_REFRESH_TICKS:  cfg_ff.refresh_ticks  <= csr_data;
            CSR_TURN_STEP:      cfg_ff.turn_step      <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/osas_core.sv
// osas_core: per-tick state update of the range latch and the scan sequencer
// computes the next state and the result word in one pass; depends on osas_pkg
module osas_core
   import osas_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [9:0]         range_cm,
   input  logic signed [15:0] heading_now,
   input  osas_cfg_type       cfg,
   output osas_rsp_type       rsp
);

   logic [9:0]  latched_ff, latched_in;
   logic [15:0] refresh_ff, refresh_in;
   logic        first_ff;
   logic        avoid_ff, avoid_in;
   logic [3:0]  phase_ff, phase_in;
   logic [15:0] dwell_ff, dwell_in;
   logic [9:0]  left_ff, left_in;
   logic [9:0]  right_ff, right_in;
   logic [15:0] goal_ff, goal_in;
   logic [7:0]  speed_ff, speed_in;

   logic [15:0] refresh_inc;
   logic [15:0] dwell_inc;
   logic [15:0] step16;
   logic [15:0] goal_plus;
   logic [15:0] goal_minus;
   logic        do_latch;

   assign refresh_inc = (refresh_ff == 16'hFFFF) ? refresh_ff : refresh_ff + 16'd1;
   assign dwell_inc   = (dwell_ff == 16'hFFFF) ? dwell_ff : dwell_ff + 16'd1;
   assign step16      = {7'd0, cfg.turn_step};
   assign goal_plus   = goal_ff + step16;
   assign goal_minus  = goal_ff - step16;
   assign do_latch    = first_ff || (refresh_inc > cfg.refresh_ticks);

   always_comb begin
      latched_in = do_latch ? range_cm : latched_ff;
      refresh_in = do_latch ? 16'd0 : refresh_inc;
      avoid_in   = avoid_ff;
      phase_in   = phase_ff;
      dwell_in   = dwell_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      goal_in    = goal_ff;
      speed_in   = speed_ff;

      if (!avoid_ff) begin
         if (latched_in > cfg.clear_distance) begin
            speed_in = cfg.cruise_speed;
            goal_in  = heading_now;
         end else begin
            avoid_in = 1'b1;
            speed_in = 8'd0;
         end
      end else if (phase_ff == PH_START) begin
         goal_in  = goal_minus;
         dwell_in = 16'd0;
         phase_in = PH_LEFT_SAMPLE;
      end else if (phase_ff > PH_RESUME) begin
         // unreachable code, recover to start
         phase_in = PH_START;
      end else if (dwell_inc <= cfg.dwell_ticks) begin
         dwell_in = dwell_inc;
      end else begin
         dwell_in = 16'd0;
         phase_in = phase_ff + 4'd1;
         case (phase_ff)
            PH_LEFT_SAMPLE:  left_in  = range_cm;
            PH_LEFT_BACK:    goal_in  = goal_plus;
            PH_TURN_RIGHT:   goal_in  = goal_plus;
            PH_RIGHT_SAMPLE: right_in = range_cm;
            PH_RIGHT_BACK:   goal_in  = goal_minus;
            PH_CHOOSE:       goal_in  = (left_ff > right_ff) ? goal_minus : goal_plus;
            PH_RESUME: begin
               speed_in = cfg.cruise_speed;
               avoid_in = 1'b0;
               phase_in = PH_START;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff <= '0;
         refresh_ff <= '0;
         first_ff   <= 1'b1;
         avoid_ff   <= 1'b0;
         phase_ff   <= PH_START;
         dwell_ff   <= '0;
         left_ff    <= '0;
         right_ff   <= '0;
         goal_ff    <= '0;
         speed_ff   <= '0;
      end else if (accept) begin
         latched_ff <= latched_in;
         refresh_ff <= refresh_in;
         first_ff   <= 1'b0;
         avoid_ff   <= avoid_in;
         phase_ff   <= phase_in;
         dwell_ff   <= dwell_in;
         left_ff    <= left_in;
         right_ff   <= right_in;
         goal_ff    <= goal_in;
         speed_ff   <= speed_in;
      end
   end

   assign rsp.drive_speed     = speed_in;
   assign rsp.target_heading  = goal_in;
   assign rsp.avoiding        = avoid_in;
   assign rsp.scan_phase      = phase_in;
   assign rsp.left_clearance  = left_in;
   assign rsp.right_clearance = right_in;

endmodule

### rtl/core/osas_rsp_buf.sv
// osas_rsp_buf: result register with one skid word
// lets a new tick in while a finished word waits; depends on osas_pkg
module osas_rsp_buf
   import osas_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  osas_rsp_type load_word,
   output logic         full,
   output logic         out_valid,
   input  logic         out_stall,
   output osas_rsp_type out_word
);

   logic         out_valid_ff;
   logic         skid_valid_ff;
   osas_rsp_type out_ff;
   osas_rsp_type skid_ff;
   logic         out_free;

   assign out_free = !out_valid_ff || !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= load;
         end
      end else if (load) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload: skid drains first, loads never happen while skid is full
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (load) begin
            out_ff <= load_word;
         end
      end else if (load) begin
         skid_ff <= load_word;
      end
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word  = out_ff;

endmodule

### rtl/core/obstacle_scan_avoid_sequencer.sv
// obstacle_scan_avoid_sequencer: top level of the range latch and scan sequencer
// instantiates osas_csr, osas_core and osas_rsp_buf; depends on osas_pkg
//
// One input word is one millisecond tick carrying range_cm and heading_now.
// Each accepted tick yields exactly one result word on the rsp_ channel:
// drive_speed, target_heading, avoiding, scan_phase and the two clearances.
// Input accepted when req_valid is high and req_stall low; output taken when
// rsp_valid is high and rsp_stall low.
// The result word is registered in the result register, or in the skid word
// while rsp_stall holds it. Throughput: one tick per cycle while req_stall
// is low; the next-state logic is a single pass from the state registers to the
// result register. A skid word behind the result register keeps the input open
// while one result waits; req_stall rises only when both are held by rsp_stall.
// Reset (synchronous): configuration returns to its defaults, the sequencer
// goes to cruising with the first-tick latch armed, and no result is pending.
// Configuration writes through csr_write/csr_index/csr_data take effect on the
// next edge; write only while no tick is in flight.
module obstacle_scan_avoid_sequencer
   import osas_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [9:0]               req_range_cm,
   input  logic signed [15:0]       req_heading_now,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_drive_speed,
   output logic signed [15:0]       rsp_target_heading,
   output logic                     rsp_avoiding,
   output logic [3:0]               rsp_scan_phase,
   output logic [9:0]               rsp_left_clearance,
   output logic [9:0]               rsp_right_clearance,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   osas_cfg_type cfg;
   osas_rsp_type core_word;
   osas_rsp_type out_word;
   logic         buf_full;
   logic         accept;

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   osas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   osas_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .range_cm    (req_range_cm),
      .heading_now (req_heading_now),
      .cfg         (cfg),
      .rsp         (core_word)
   );

   osas_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_word (core_word),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word)
   );

   assign rsp_drive_speed     = out_word.drive_speed;
   assign rsp_target_heading  = out_word.target_heading;
   assign rsp_avoiding        = out_word.avoiding;
   assign rsp_scan_phase      = out_word.scan_phase;
   assign rsp_left_clearance  = out_word.left_clearance;
   assign rsp_right_clearance = out_word.right_clearance;

endmodule

### rtl/core/osas_checker.sv
// osas_checker: port-level checks of the obstacle scan/avoid sequencer
// bound to obstacle_scan_avoid_sequencer; depends on osas_pkg
module osas_checker
   import osas_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [7:0]         rsp_drive_speed,
   input logic               rsp_avoiding,
   input logic [3:0]         rsp_scan_phase
);

   // no pending word and input open right after reset
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("result pending or input stalled after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result word dropped while stalled");

   // cruising words always report phase start
   a_cruise_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_avoiding) |-> (rsp_scan_phase == PH_START))
      else $error("scan phase nonzero while cruising");

   a_scan_stopped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_avoiding) |-> (rsp_drive_speed == 8'd0))
      else $error("nonzero speed during scan");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_scan_phase <= PH_RESUME))
      else $error("scan phase out of range");

endmodule

bind obstacle_scan_avoid_sequencer osas_checker u_osas_checker (.*);
